/* src/sxtq_pkg.sv */
// Package for the sorted expiry timer queue: beat structs, cell entry and
// control types, operation, status and cell command codes. No dependencies.
package sxtq_pkg;

  localparam int HANDLE_W    = 10;
  localparam int TIME_W      = 32;
  localparam int MAX_RESULTS = 32;
  localparam int POP_W       = $clog2(MAX_RESULTS);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_ADJUST = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_DUPLICATE = 2'd3;

  localparam logic [2:0] CMD_HOLD   = 3'd0;
  localparam logic [2:0] CMD_LOOK   = 3'd1;
  localparam logic [2:0] CMD_INSERT = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_POP    = 3'd4;

  typedef struct packed {
    logic [1:0]          op;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   expires_at;
    logic [TIME_W-1:0]   now_time;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic                expired;
    logic [1:0]          status;
    logic                last;
  } result_t;

  typedef struct packed {
    logic                valid;
    logic [TIME_W-1:0]   expiry;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [TIME_W-1:0]   key_time;
    logic [HANDLE_W-1:0] key_handle;
  } cell_ctl_t;

endpackage

/* src/sorted_expiry_timer_queue.sv */
// Top level of the sorted expiry timer queue: command sequencer and the chain
// of sxtq_cell instances. Depends on sxtq_pkg and sxtq_cell.
//
// The queue keeps up to DEPTH timers in ascending order of expiry, one per
// cell, each tagged with a connection handle. A command beat is taken when
// start is high and busy is low; busy rises at the edge that takes the command
// and falls in the cycle that presents its last result beat, so the next
// command beat can be taken at the edge that ends that cycle. Each result beat
// is on the result port for exactly one cycle, flagged by done, and the
// receiver cannot stall it.
// Add, delete and adjust give one result beat each: add steps through
// capture, handle search across all cells and insertion, delete through
// capture, search and removal, and adjust through capture, search, removal
// and reinsertion, as the entry is removed and reinserted in two shifts. A tick
// is captured and then pops one expired timer per cycle from the head cell, up
// to MAX_RESULTS beats, the final one marked last; a tick that finds nothing
// expired gives one beat that echoes the handle with expired low. Each result
// appears in the cycle after the one that computes it: the port is registered.
// The store needs no clearing pass: reset clears the occupancy bit of every
// cell at once.
module sorted_expiry_timer_queue
  import sxtq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    req,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LOOK     = 3'd1;
  localparam logic [2:0] S_APPLY    = 3'd2;
  localparam logic [2:0] S_REINSERT = 3'd3;
  localparam logic [2:0] S_POP      = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  req_t             cur;
  logic [POP_W-1:0] pop_n;
  logic [POP_W-1:0] pop_n_next;
  logic             done_next;
  result_t          result_next;
  cell_ctl_t        ctl;

  // Chain wiring: each cell sees its left and right neighbours.
  entry_t           ents [DEPTH];
  logic [DEPTH-1:0] gts;
  logic [DEPTH-1:0] hits;
  logic [DEPTH-1:0] valids;
  logic [DEPTH:0]   chain;

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_gt;

    if (i == 0) begin : g_head
      // The head has a permanently occupied, never-later neighbour.
      assign left_ent = '{valid: 1'b1, expiry: '0, handle: '0};
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_ent = ents[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    sxtq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .left     (left_ent),
      .left_gt  (left_gt),
      .right    (right_ent),
      .chain_in (chain[i]),
      .chain_out(chain[i+1]),
      .ent      (ents[i]),
      .gt       (gts[i]),
      .hit      (hits[i])
    );

    assign valids[i] = ents[i].valid;
  end

  logic found;
  logic full;
  logic head_due;
  logic next_due;

  assign found    = |hits;
  assign full     = valids[DEPTH-1];
  assign head_due = ents[0].valid && (ents[0].expiry <= cur.now_time);
  // After a pop the second cell becomes the head, so it decides whether
  // this beat is the last one of the tick.
  assign next_due = ents[1].valid && (ents[1].expiry <= cur.now_time);

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    pop_n_next  = pop_n;
    done_next   = 1'b0;
    result_next = '{handle_out: cur.handle, expired: 1'b0, status: ST_OK, last: 1'b1};
    ctl         = '{cmd: CMD_HOLD, key_time: cur.expires_at, key_handle: cur.handle};
    case (state)
      S_IDLE: begin
        if (start) begin
          pop_n_next = '0;
          state_next = (req.op == OP_TICK) ? S_POP : S_LOOK;
        end
      end
      S_LOOK: begin
        ctl.cmd    = CMD_LOOK;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (cur.op == OP_ADD) begin
          if (found) begin
            result_next.status = ST_DUPLICATE;
          end else if (full) begin
            result_next.status = ST_FULL;
          end else begin
            ctl.cmd = CMD_INSERT;
          end
        end else if (!found) begin
          result_next.status = ST_NOT_FOUND;
        end else begin
          ctl.cmd = CMD_DELETE;
          if (cur.op == OP_ADJUST) begin
            // The result beat waits for the reinsertion.
            done_next  = 1'b0;
            state_next = S_REINSERT;
          end
        end
      end
      S_REINSERT: begin
        ctl.cmd    = CMD_INSERT;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_POP: begin
        done_next = 1'b1;
        if (head_due) begin
          ctl.cmd                = CMD_POP;
          result_next.handle_out = ents[0].handle;
          result_next.expired    = 1'b1;
          result_next.last       = (pop_n == POP_W'(MAX_RESULTS - 1)) || !next_due;
          pop_n_next             = pop_n + 1'b1;
          if (result_next.last) begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    pop_n  <= pop_n_next;
    result <= result_next;
    if (start && !busy) begin
      cur <= req;
    end
  end

  // Occupied cells always form an unbroken run from the head.
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (valids & (valids + 1'b1)) == '0)
    else $error("occupied cells are not contiguous from the head");

  // Neighbouring occupied cells stay in order of expiry.
  for (genvar j = 0; j + 1 < DEPTH; j++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      ents[j+1].valid |-> (ents[j].expiry <= ents[j+1].expiry))
      else $error("timer chain out of order");
  end

  // A result beat only follows a cycle of work on a command.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a command in progress");

  // The last beat of a command frees the block; any other beat keeps it busy.
  a_last_free: assert property (@(posedge clk) disable iff (rst)
    (done && result.last) |-> !busy)
    else $error("still busy after the last result beat");

  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last) |-> busy)
    else $error("idle although more result beats are due");

endmodule

/* src/sxtq_cell.sv */
// One cell of the sorted timer chain: holds a single entry and a match flag.
// Depends on sxtq_pkg for the entry and control types and the command codes.
module sxtq_cell
  import sxtq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    left,
  input  logic      left_gt,
  input  entry_t    right,
  input  logic      chain_in,
  output logic      chain_out,
  output entry_t    ent,
  output logic      gt,
  output logic      hit
);

  entry_t ent_next;
  logic   hit_next;

  always_comb begin
    gt        = ent.valid && (ent.expiry > ctl.key_time);
    chain_out = chain_in | hit;
    ent_next  = ent;
    hit_next  = hit;
    case (ctl.cmd)
      CMD_LOOK: begin
        hit_next = ent.valid && (ent.handle == ctl.key_handle);
      end
      CMD_INSERT: begin
        // Entries later than the key move one place down; the first free or
        // later slot after an occupied, not-later neighbour takes the key.
        if (left_gt) begin
          ent_next = left;
        end else if (left.valid && (!ent.valid || gt)) begin
          ent_next = '{valid: 1'b1, expiry: ctl.key_time, handle: ctl.key_handle};
        end
      end
      CMD_DELETE: begin
        if (chain_out) begin
          ent_next = right;
        end
      end
      CMD_POP: begin
        ent_next = right;
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.expiry <= ent_next.expiry;
    ent.handle <= ent_next.handle;
    hit        <= hit_next;
  end

endmodule
